// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler modules.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge out of reset.
`define PPS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PPS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
// Used by pps_ctrl, pps_datapath and the top level; no dependencies.
package pps_pkg;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [4:0] DONE_MAX      = 5'd31;
	localparam logic [4:0] JOB_COUNT_RST = 5'd16;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [31:0] first_run;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan_start;
		logic scan_rd;
		logic update;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
	} stat_t;

endpackage

// ===== rtl/preemptive_priority_scheduler_top.sv =====
// Preemptive priority scheduler, top level.
// Input channel carries load, tick and clear beats; output channel carries one beat per tick.
// Config channel writes job_count. Reset arst_n clears the table, time and done count
// and sets job_count to 16.
// Load and clear give no output beat; action 3 is dropped.
// A tick scans every slot through one table read port, one slot per cycle, then
// passes the drain, update and result states: the chosen job is updated and its
// output beat registered. The next input beat is taken only once the tick is
// back in idle, since the slot scan is serial.
// The result sits in an output register until out_ready takes it; loads and
// clears are still accepted meanwhile. A following tick holds in its last step
// until that register is free, so out_ready low stalls ticks only.
// The config channel is always ready; write it only while no tick is in flight.
// Time wraps modulo 2^TIME_BITS; times on the output are its low 32 bits.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
module preemptive_priority_scheduler_top #(
	parameter int MAX_JOBS  = 16,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  slot,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic [7:0]  job_priority,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ran,
	output logic [3:0]  running_slot,
	output logic [31:0] tick_start,
	output logic        finished,
	output logic [31:0] start_time,
	output logic [31:0] finish_time,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	output logic        all_done
);
	import pps_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pps_datapath #(
		.MAX_JOBS  (MAX_JOBS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.slot         (slot),
		.arrival_time (arrival_time),
		.burst_length (burst_length),
		.job_priority (job_priority),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.ran          (ran),
		.running_slot (running_slot),
		.tick_start   (tick_start),
		.finished     (finished),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.turnaround   (turnaround),
		.waiting      (waiting),
		.all_done     (all_done)
	);

endmodule

// ===== rtl/pps_ctrl.sv =====
// Controller state machine of the scheduler: sequences load, clear and tick.
// Depends on pps_pkg and assert_macros.svh; drives pps_datapath by commands.
`include "assert_macros.svh"

module pps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     action,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pps_pkg::stat_t stat,
	output pps_pkg::cmd_t  cmd
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.load        = accept && (action == ACT_LOAD);
		cmd.clear       = accept && (action == ACT_CLEAR);
		cmd.scan_start  = accept && (action == ACT_TICK);
		cmd.scan_rd     = (state_q == ST_SCAN);
		cmd.update      = (state_q == ST_UPDATE);
		cmd.result_load = (state_q == ST_RESULT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.scan_start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (stat.idx_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PPS_ASSERT_NEXT(a_result_shown, cmd.result_load, out_valid_q, "result beat not presented")
	`PPS_ASSERT_NEXT(a_scan_ends, cmd.scan_rd && stat.idx_last, state_q == ST_DRAIN, "scan overran table")
	`PPS_ASSERT(a_no_overwrite, cmd.result_load |-> (!out_valid_q || out_ready), "result overwritten")

endmodule

// ===== rtl/pps_datapath.sv =====
// Datapath of the scheduler: job table memory, scan compare, time and completion math.
// Depends on pps_pkg and assert_macros.svh; commanded by pps_ctrl.
`include "assert_macros.svh"

module pps_datapath #(
	parameter int MAX_JOBS  = 16,
	parameter int TIME_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [3:0]     slot,
	input  logic [15:0]    arrival_time,
	input  logic [15:0]    burst_length,
	input  logic [7:0]     job_priority,
	input  logic           cfg_wr,
	input  logic [4:0]     cfg_data,
	input  pps_pkg::cmd_t  cmd,
	output pps_pkg::stat_t stat,
	output logic           ran,
	output logic [3:0]     running_slot,
	output logic [31:0]    tick_start,
	output logic           finished,
	output logic [31:0]    start_time,
	output logic [31:0]    finish_time,
	output logic [31:0]    turnaround,
	output logic [31:0]    waiting,
	output logic           all_done
);
	import pps_pkg::*;

	localparam int SLOT_W = $clog2(MAX_JOBS);
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_JOBS - 1);

	entry_t              mem [MAX_JOBS];
	logic [MAX_JOBS-1:0] live_q;

	logic [SLOT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]    rd_idx_s1;
	logic                 rd_vld_s1;
	logic                 rd_live_s1;
	entry_t               rd_s1;
	logic                 found_q;
	logic [SLOT_W-1:0]    best_idx_q;
	entry_t               best_q;
	logic [TIME_BITS-1:0] time_q;
	logic [4:0]           done_q;
	logic [4:0]           job_count_q;

	logic        res_ran_q;
	logic        res_fin_q;
	logic [31:0] res_tick_q;
	logic [31:0] res_start_q;
	logic [31:0] res_finish_q;
	logic [31:0] res_tat_q;

	logic                 load_ok;
	logic [31:0]          slot_ext;
	logic [SLOT_W-1:0]    load_addr;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	entry_t               wr_entry;
	entry_t               run_entry;
	logic [15:0]          cand_rem;
	logic                 cand_ready;
	logic                 better;
	logic                 take;
	logic [TIME_BITS-1:0] time_next;
	logic [63:0]          now_w;
	logic [63:0]          next_w;
	logic [31:0]          now32;
	logic [31:0]          next32;
	logic [15:0]          rem_new;
	logic                 fin_now;
	logic [31:0]          best_ext;

	assign slot_ext  = 32'(slot);
	assign load_addr = slot_ext[SLOT_W-1:0];
	assign load_ok   = cmd.load && (burst_length != 16'd0) && (slot_ext < 32'(MAX_JOBS));

	assign time_next = time_q + TIME_BITS'(1);
	assign now_w     = 64'(time_q);
	assign next_w    = 64'(time_next);
	assign now32     = now_w[31:0];
	assign next32    = next_w[31:0];
	assign rem_new   = best_q.remaining - 16'd1;
	assign fin_now   = found_q && (rem_new == 16'd0);
	assign best_ext  = 32'(best_idx_q);

	always_comb begin
		run_entry           = best_q;
		run_entry.remaining = rem_new;
		if (best_q.remaining == best_q.burst) run_entry.first_run = now32;
	end

	assign wr_en   = load_ok || (cmd.update && found_q);
	assign wr_addr = cmd.update ? best_idx_q : load_addr;
	assign wr_entry = cmd.update ? run_entry :
		entry_t'{arrival: arrival_time, burst: burst_length, prio: job_priority,
		  remaining: burst_length, first_run: 32'd0};

	assign cand_rem   = rd_live_s1 ? rd_s1.remaining : 16'd0;
	assign cand_ready = (cand_rem != 16'd0) && (TIME_BITS'(rd_s1.arrival) <= time_q);
	assign better     = !found_q || (rd_s1.prio < best_q.prio) ||
		((rd_s1.prio == best_q.prio) && (rd_s1.arrival < best_q.arrival));
	assign take       = rd_vld_s1 && cand_ready && better;

	assign stat.idx_last = (idx_q == LAST_IDX);

	// job table
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_entry;
		rd_s1     <= mem[idx_q];
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_live_s1  <= 1'b0;
			found_q     <= 1'b0;
			time_q      <= '0;
			done_q      <= '0;
			job_count_q <= JOB_COUNT_RST;
		end else begin
			rd_vld_s1  <= cmd.scan_rd;
			rd_live_s1 <= live_q[idx_q];
			if (cfg_wr) job_count_q <= cfg_data;
			if (cmd.clear) begin
				live_q <= '0;
				time_q <= '0;
				done_q <= '0;
			end else if (load_ok) begin
				live_q[load_addr] <= 1'b1;
			end
			if (cmd.scan_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd && !stat.idx_last) idx_q <= idx_q + SLOT_W'(1);
				if (take) found_q <= 1'b1;
			end
			if (cmd.update) begin
				time_q <= time_next;
				if (fin_now && (done_q < DONE_MAX)) done_q <= done_q + 5'd1;
			end
		end
	end

	// best candidate, completion staging and result beat
	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_s1;
		end
		if (cmd.update) begin
			res_ran_q    <= found_q;
			res_fin_q    <= fin_now;
			res_tick_q   <= now32;
			res_start_q  <= run_entry.first_run;
			res_finish_q <= next32;
			res_tat_q    <= next32 - 32'(best_q.arrival);
		end
		if (cmd.result_load) begin
			ran          <= res_ran_q;
			running_slot <= res_ran_q ? best_ext[3:0] : 4'd0;
			tick_start   <= res_tick_q;
			finished     <= res_fin_q;
			start_time   <= res_fin_q ? res_start_q : 32'd0;
			finish_time  <= res_fin_q ? res_finish_q : 32'd0;
			turnaround   <= res_fin_q ? res_tat_q : 32'd0;
			waiting      <= res_fin_q ? (res_tat_q - 32'(best_q.burst)) : 32'd0;
			all_done     <= (done_q >= job_count_q);
		end
	end

	`PPS_ASSERT(a_idx_range, idx_q <= LAST_IDX, "scan index beyond table")
	`PPS_ASSERT(a_best_live, (cmd.update && found_q) |-> (best_q.remaining != 16'd0), "chosen job has no time left")

endmodule

// ===== bench/preemptive_priority_scheduler_top_test.sv =====
// Self-checking bench for preemptive_priority_scheduler_top: directed and random load/tick/clear
// beats, a scoreboard class that predicts each tick report, random stalls on both channels.
// Depends on pps_pkg and the scheduler RTL.
module preemptive_priority_scheduler_top_test;
	import pps_pkg::*;

	localparam int MAX_JOBS = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * (MAX_JOBS + 4);
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  slot;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} sched_req_t;

	typedef struct packed {
		logic        ran;
		logic [3:0]  running_slot;
		logic [31:0] tick_start;
		logic        finished;
		logic [31:0] start_time;
		logic [31:0] finish_time;
		logic [31:0] turnaround;
		logic [31:0] waiting;
		logic        all_done;
	} tick_report_t;

	class tick_scoreboard;
		logic [15:0] arrival_tbl[MAX_JOBS];
		logic [15:0] burst_tbl[MAX_JOBS];
		logic [7:0]  prio_tbl[MAX_JOBS];
		logic [15:0] left_tbl[MAX_JOBS];
		logic [31:0] first_run_tbl[MAX_JOBS];
		logic [31:0] sched_time;
		logic [4:0]  done_cnt;
		logic [4:0]  job_count;
		tick_report_t expected_reports[$];
		int mismatches;

		function new();
			empty_table();
			job_count = JOB_COUNT_RST;
			mismatches = 0;
		endfunction

		function void empty_table();
			for (int i = 0; i < MAX_JOBS; i++) begin
				arrival_tbl[i] = '0;
				burst_tbl[i] = '0;
				prio_tbl[i] = '0;
				left_tbl[i] = '0;
				first_run_tbl[i] = '0;
			end
			sched_time = '0;
			done_cnt = '0;
		endfunction

		function void set_job_count(logic [4:0] value);
			job_count = value;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void note_request(sched_req_t req);
			tick_report_t rep;
			int best;
			bit found;
			case (req.action)
				ACT_LOAD: begin
					if (req.burst != 16'd0) begin
						arrival_tbl[req.slot] = req.arrival;
						burst_tbl[req.slot] = req.burst;
						prio_tbl[req.slot] = req.prio;
						left_tbl[req.slot] = req.burst;
					end
				end
				ACT_CLEAR: empty_table();
				ACT_TICK: begin
					rep = '0;
					best = 0;
					found = 1'b0;
					for (int i = 0; i < MAX_JOBS; i++) begin
						if (left_tbl[i] != 16'd0 && {16'd0, arrival_tbl[i]} <= sched_time) begin
							if (!found || prio_tbl[i] < prio_tbl[best] ||
									(prio_tbl[i] == prio_tbl[best] &&
									arrival_tbl[i] < arrival_tbl[best])) begin
								best = i;
								found = 1'b1;
							end
						end
					end
					rep.tick_start = sched_time;
					sched_time = sched_time + 32'd1;
					if (found) begin
						rep.ran = 1'b1;
						rep.running_slot = best[3:0];
						if (left_tbl[best] == burst_tbl[best])
							first_run_tbl[best] = rep.tick_start;
						left_tbl[best] = left_tbl[best] - 16'd1;
						if (left_tbl[best] == 16'd0) begin
							rep.finished = 1'b1;
							rep.start_time = first_run_tbl[best];
							rep.finish_time = sched_time;
							rep.turnaround = sched_time - {16'd0, arrival_tbl[best]};
							rep.waiting = rep.turnaround - {16'd0, burst_tbl[best]};
							if (done_cnt < DONE_MAX)
								done_cnt = done_cnt + 5'd1;
						end
					end
					rep.all_done = (done_cnt >= job_count);
					expected_reports.push_back(rep);
				end
				default: ;
			endcase
		endfunction

		function void check_report(tick_report_t got);
			tick_report_t want;
			string bad;
			bad = "";
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected report beat: got %p", got);
				return;
			end
			want = expected_reports.pop_front();
			if (got.ran !== want.ran) bad = {bad, " ran"};
			if (got.running_slot !== want.running_slot) bad = {bad, " running_slot"};
			if (got.tick_start !== want.tick_start) bad = {bad, " tick_start"};
			if (got.finished !== want.finished) bad = {bad, " finished"};
			if (got.start_time !== want.start_time) bad = {bad, " start_time"};
			if (got.finish_time !== want.finish_time) bad = {bad, " finish_time"};
			if (got.turnaround !== want.turnaround) bad = {bad, " turnaround"};
			if (got.waiting !== want.waiting) bad = {bad, " waiting"};
			if (got.all_done !== want.all_done) bad = {bad, " all_done"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("report mismatch in%s: expected %p, got %p", bad, want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [3:0]  slot;
	logic [15:0] arrival_time;
	logic [15:0] burst_length;
	logic [7:0]  job_priority;
	logic        out_valid;
	logic        out_ready;
	logic        ran;
	logic [3:0]  running_slot;
	logic [31:0] tick_start;
	logic        finished;
	logic [31:0] start_time;
	logic [31:0] finish_time;
	logic [31:0] turnaround;
	logic [31:0] waiting;
	logic        all_done;

	tick_scoreboard tick_sb;
	int send_calm;
	int work_items;
	int cycle_count;

	preemptive_priority_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.slot(slot),
		.arrival_time(arrival_time),
		.burst_length(burst_length),
		.job_priority(job_priority),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ran(ran),
		.running_slot(running_slot),
		.tick_start(tick_start),
		.finished(finished),
		.start_time(start_time),
		.finish_time(finish_time),
		.turnaround(turnaround),
		.waiting(waiting),
		.all_done(all_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic int draw_gap(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 30) == 0) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic sched_req_t make_req(logic [1:0] act, logic [3:0] s, logic [15:0] arr,
			logic [15:0] len, logic [7:0] prio);
		sched_req_t req;
		req.action = act;
		req.slot = s;
		req.arrival = arr;
		req.burst = len;
		req.prio = prio;
		return req;
	endfunction

	function automatic sched_req_t random_job(logic [31:0] now, bit allow_hog);
		sched_req_t req;
		int pick;
		req.action = ACT_LOAD;
		req.slot = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 15) == 0)
			req.arrival = 16'($urandom_range(0, 16'hFFFF));
		else
			req.arrival = now[15:0] + 16'($urandom_range(0, 20)) - 16'd4;
		req.prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			req.burst = 16'd0;
		end else if (pick == 1) begin
			req.burst = 16'($urandom_range(1, 16'hFFFF));
			if (!allow_hog)
				req.prio = 8'hFF;
		end else begin
			req.burst = 16'($urandom_range(1, 6));
		end
		return req;
	endfunction

	task automatic send_request(input sched_req_t req);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= req.action;
		slot <= req.slot;
		arrival_time <= req.arrival;
		burst_length <= req.burst;
		job_priority <= req.prio;
		do @(posedge clk); while (!in_ready);
		tick_sb.note_request(req);
		if (!(req.action == ACT_UNUSED || (req.action == ACT_LOAD && req.burst == 16'd0)))
			work_items++;
	endtask

	task automatic write_job_count(input logic [4:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tick_sb.set_job_count(value);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tick_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_tick();
		send_request(make_req(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom)));
	endtask

	initial begin : report_sink
		int gap;
		int calm;
		int taken;
		tick_report_t got;
		calm = 0;
		taken = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = (taken == 40 || taken == 700) ? HOLD_CYCLES : draw_gap(calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{ran, running_slot, tick_start, finished, start_time, finish_time,
				turnaround, waiting, all_done};
			tick_sb.check_report(got);
			taken++;
		end
	end

	initial begin : stimulus
		int n;
		int ticks;
		logic [4:0] job_cfg;
		bit keep_table;
		sched_req_t req;
		tick_sb = new();
		send_calm = 0;
		work_items = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		slot = '0;
		arrival_time = '0;
		burst_length = '0;
		job_priority = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_job_count(5'd3);

		send_tick();
		send_request(make_req(ACT_LOAD, 4'd0, 16'd0, 16'd0, 8'd5));
		send_request(make_req(ACT_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_request(make_req(ACT_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF));
		send_request(make_req(ACT_LOAD, 4'd3, 16'd2, 16'd2, 8'd0));
		send_request(make_req(ACT_LOAD, 4'd5, 16'd0, 16'd3, 8'd7));
		send_request(make_req(ACT_LOAD, 4'd6, 16'd0, 16'd1, 8'd7));
		send_request(make_req(ACT_LOAD, 4'd7, 16'd1, 16'd1, 8'd7));
		repeat (3) send_tick();
		send_request(make_req(ACT_LOAD, 4'd5, 16'd0, 16'd2, 8'd7));
		repeat (4) send_tick();
		send_request(make_req(ACT_LOAD, 4'd0, 16'd0, 16'd1, 8'd0));
		repeat (2) send_tick();
		send_request(make_req(ACT_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0));
		send_tick();
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: job_cfg = 5'd1;
				1: job_cfg = 5'd16;
				2: job_cfg = 5'd0;
				3: job_cfg = DONE_MAX;
				default: job_cfg = 5'($urandom_range(0, 31));
			endcase
			keep_table = (job_cfg == DONE_MAX);
			write_job_count(job_cfg);
			work_items = 0;
			while (work_items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 5) == 0) begin
					req = make_req(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
						16'($urandom), 8'($urandom));
					if (keep_table && req.action == ACT_CLEAR)
						req.action = ACT_TICK;
					if (keep_table && req.action == ACT_LOAD)
						req.burst = {13'd0, req.burst[2:0]};
					send_request(req);
				end else begin
					if (!keep_table && $urandom_range(0, 4) != 0)
						send_request(make_req(ACT_CLEAR, 4'($urandom), 16'($urandom),
							16'($urandom), 8'($urandom)));
					n = $urandom_range(1, MAX_JOBS);
					repeat (n) send_request(random_job(tick_sb.sched_time, !keep_table));
					ticks = $urandom_range(4, 48);
					repeat (ticks) begin
						if ($urandom_range(0, 9) == 0)
							send_request(random_job(tick_sb.sched_time, !keep_table));
						else
							send_tick();
					end
				end
			end
			drain();
		end

		if (tick_sb.mismatches == 0 && tick_sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_ctrl.sv
rtl/pps_datapath.sv
rtl/preemptive_priority_scheduler_top.sv
bench/preemptive_priority_scheduler_top_test.sv
